>>> sv/sgpd_pkg.sv
package sgpd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_ROUNDS = 1'b1;

    localparam int SECTOR_W = 13;
    localparam logic [SECTOR_W-1:0] SECTOR_SIZE_RESET = 13'd512;

    localparam int BYTES_W = 32;
    localparam int ADDR_W = 64;
    localparam int LEN_W = 27;
    localparam int CM1_W = 22;
    localparam int SLOT_IDX_W = 4;

    // results per input transaction
    localparam int RESULT_LIMIT = 32;
    localparam int NRES_W = 6;

    // remainder unit: dividend is round bytes plus piece
    localparam int DVD_W = BYTES_W + 1;
    localparam int DCNT_W = 6;

    localparam int IN_TDATA_W = 128;
    localparam int OUT_TDATA_W = 96;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PIECE  = 6'b000010,
        S_CHECK  = 6'b000100,
        S_MOD    = 6'b001000,
        S_COMMIT = 6'b010000,
        S_FAIL   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load_start;
        logic load_entry;
        logic calc_piece;
        logic start_rem;
        logic trim;
        logic commit;
        logic commit_err;
    } cmd_t;

    typedef struct packed {
        logic is_entry;
        logic more;
        logic need_trim;
        logic rem_done;
        logic rem_zero;
        logic trim_fail;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     piece_address;
        logic [CM1_W-1:0]      count_minus_one;
        logic                  interrupt_on_done;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  round_end;
        logic                  transfer_done;
        logic                  align_error;
        logic                  last;
    } desc_t;

endpackage

>>> sv/sgpd_rem.sv
module sgpd_rem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sgpd_pkg::DVD_W-1:0]    dividend,
    input  logic [sgpd_pkg::SECTOR_W-1:0] divisor,
    output logic                          done,
    output logic [sgpd_pkg::SECTOR_W-1:0] remainder
);
    import sgpd_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [SECTOR_W-1:0] div_reg, div_next;
    logic [SECTOR_W:0]   rem_reg, rem_next;
    logic [SECTOR_W:0]   shifted;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg[SECTOR_W-1:0], dvd_reg[DVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DVD_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg})
                rem_next = shifted - {1'b0, div_reg};
            else
                rem_next = shifted;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[SECTOR_W-1:0];

endmodule

>>> sv/sgpd_ctrl.sv
module sgpd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sgpd_pkg::status_t status,
    output sgpd_pkg::cmd_t    cmd
);
    import sgpd_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.is_entry)
                    begin
                        cmd.load_entry = 1'b1;
                        state_next     = S_PIECE;
                    end
                    else
                        cmd.load_start = 1'b1;
                end
            end
            S_PIECE:
            begin
                if (status.more)
                begin
                    cmd.calc_piece = 1'b1;
                    state_next     = S_CHECK;
                end
                else
                    state_next = S_IDLE;
            end
            S_CHECK:
            begin
                if (status.need_trim)
                begin
                    cmd.start_rem = 1'b1;
                    state_next    = S_MOD;
                end
                else if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_PIECE;
                end
            end
            S_MOD:
            begin
                if (status.rem_done)
                begin
                    if (!status.rem_zero && status.trim_fail)
                        state_next = S_FAIL;
                    else
                    begin
                        cmd.trim   = 1'b1;
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_PIECE;
                end
            end
            S_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.commit_err = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/sgpd_dpath.sv
module sgpd_dpath
#(
    parameter int PRDT_SLOTS      = 16,
    parameter int MAX_PIECE_BYTES = 4194304
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sgpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgpd_pkg::SECTOR_W-1:0]  cfg_data,
    input  logic                           in_kind,
    input  logic [sgpd_pkg::BYTES_W-1:0]   in_transfer_bytes,
    input  logic [sgpd_pkg::ADDR_W-1:0]    in_sg_address,
    input  logic [sgpd_pkg::LEN_W-1:0]     in_sg_length,
    input  logic                           out_ready,
    output logic                           out_valid,
    output sgpd_pkg::desc_t                out_desc,
    input  sgpd_pkg::cmd_t                 cmd,
    output sgpd_pkg::status_t              status
);
    import sgpd_pkg::*;

    localparam int SLOT_W  = $clog2(PRDT_SLOTS);
    localparam int PIECE_W = $clog2(MAX_PIECE_BYTES + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PRDT_SLOTS - 1);

    logic [SECTOR_W-1:0] sector_size_reg;
    logic                align_reg;

    logic [BYTES_W-1:0]  br_reg;      // bytes remaining in transfer
    logic [BYTES_W-1:0]  rb_reg;      // bytes in open round
    logic [SLOT_W-1:0]   slot_reg;
    logic                err_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_W-1:0]    left_reg;    // bytes of entry not yet cut
    logic [NRES_W-1:0]   nres_reg;
    logic [PIECE_W-1:0]  piece_reg;
    logic                out_valid_reg;
    desc_t               desc_reg;

    logic [SECTOR_W-1:0] ss_eff;
    logic [BYTES_W-1:0]  piece_w;
    logic [BYTES_W-1:0]  piece_min;
    logic                slot_last;
    logic                xfer_done;
    logic                close;
    logic                last_res;
    logic [BYTES_W-1:0]  cm1_wide;
    logic [SLOT_W+SLOT_IDX_W-1:0] slot_ext;
    logic                rem_done;
    logic [SECTOR_W-1:0] rem_val;

    assign ss_eff    = (sector_size_reg == '0) ? SECTOR_W'(1) : sector_size_reg;
    assign piece_w   = BYTES_W'(piece_reg);
    assign slot_last = (slot_reg == SLOT_LAST);
    assign xfer_done = (br_reg == piece_w);
    assign close     = slot_last || xfer_done;
    assign last_res  = xfer_done || (BYTES_W'(left_reg) == piece_w) ||
                       (nres_reg == NRES_W'(RESULT_LIMIT - 1));
    assign cm1_wide  = piece_w - BYTES_W'(1);
    assign slot_ext  = {{SLOT_IDX_W{1'b0}}, slot_reg};

    always_comb
    begin
        piece_min = BYTES_W'(MAX_PIECE_BYTES);
        if (br_reg < piece_min)
            piece_min = br_reg;
        if (BYTES_W'(left_reg) < piece_min)
            piece_min = BYTES_W'(left_reg);
    end

    sgpd_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_rem),
        .dividend  ({1'b0, rb_reg} + DVD_W'(piece_reg)),
        .divisor   (ss_eff),
        .done      (rem_done),
        .remainder (rem_val)
    );

    always_comb
    begin
        status.is_entry  = in_kind;
        status.more      = !err_reg && (br_reg != '0) && (left_reg != '0) &&
                           (nres_reg != NRES_W'(RESULT_LIMIT));
        status.need_trim = slot_last && align_reg && (piece_w != br_reg);
        status.rem_done  = rem_done;
        status.rem_zero  = (rem_val == '0);
        status.trim_fail = (piece_w < BYTES_W'(ss_eff));
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_size_reg <= SECTOR_SIZE_RESET;
            align_reg       <= 1'b1;
            br_reg          <= '0;
            rb_reg          <= '0;
            slot_reg        <= '0;
            err_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SECTOR_SIZE:  sector_size_reg <= cfg_data;
                    REG_ALIGN_ROUNDS: align_reg       <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (cmd.load_start)
            begin
                br_reg   <= in_transfer_bytes;
                rb_reg   <= '0;
                slot_reg <= '0;
                err_reg  <= 1'b0;
            end
            if (cmd.commit)
            begin
                br_reg <= br_reg - piece_w;
                if (close)
                begin
                    rb_reg   <= '0;
                    slot_reg <= '0;
                end
                else
                begin
                    rb_reg   <= rb_reg + piece_w;
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            if (cmd.commit_err)
                err_reg <= 1'b1;
            if (cmd.commit || cmd.commit_err)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            addr_reg <= in_sg_address;
            left_reg <= in_sg_length;
            nres_reg <= '0;
        end
        if (cmd.calc_piece)
            piece_reg <= piece_min[PIECE_W-1:0];
        if (cmd.trim)
            piece_reg <= piece_reg - PIECE_W'(rem_val);
        if (cmd.commit)
        begin
            addr_reg <= addr_reg + ADDR_W'(piece_reg);
            left_reg <= left_reg - LEN_W'(piece_reg);
            nres_reg <= nres_reg + 1'b1;
            desc_reg.piece_address     <= addr_reg;
            desc_reg.count_minus_one   <= cm1_wide[CM1_W-1:0];
            desc_reg.interrupt_on_done <= close;
            desc_reg.slot_index        <= slot_ext[SLOT_IDX_W-1:0];
            desc_reg.round_end         <= close;
            desc_reg.transfer_done     <= xfer_done;
            desc_reg.align_error       <= 1'b0;
            desc_reg.last              <= last_res;
        end
        if (cmd.commit_err)
        begin
            nres_reg <= nres_reg + 1'b1;
            desc_reg.piece_address     <= '0;
            desc_reg.count_minus_one   <= '0;
            desc_reg.interrupt_on_done <= 1'b0;
            desc_reg.slot_index        <= slot_ext[SLOT_IDX_W-1:0];
            desc_reg.round_end         <= 1'b0;
            desc_reg.transfer_done     <= 1'b0;
            desc_reg.align_error       <= 1'b1;
            desc_reg.last              <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_desc  = desc_reg;

endmodule

>>> sv/sg_to_prdt_descriptor_builder_core.sv
// Channel   Dir  tdata (low bit up)                                  tuser          tlast
// s_axis    in   transfer_bytes, sg_address, sg_length, pad           opcode         -
// m_axis    out  piece_address, count_minus_one, interrupt_on_done,   align_error    last
//                slot_index, round_end, transfer_done, pad
// cfg       in   write: cfg_index 0 sector_size, 1 align_rounds       -              -
//
// One input transaction at a time. Each descriptor takes a piece select and a
// commit; a round-closing slot that needs trimming adds a wait on the
// bit-serial remainder unit (33 dividend bits) and the trim step.
// A start transaction is taken without leaving idle; an entry is accepted, and the
// piece step runs once more after its last descriptor, but not after an error result.
// Reset is asynchronous: sector_size 512, align on, transfer state cleared.
// A stalled output holds the next commit; input is taken while a result waits.
module sg_to_prdt_descriptor_builder_core
#(
    parameter int PRDT_SLOTS      = 16,
    parameter int MAX_PIECE_BYTES = 4194304
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sgpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgpd_pkg::SECTOR_W-1:0]     cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // transfer_bytes[31:0], sg_address[95:32], sg_length[122:96], zero pad
    input  logic [sgpd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // piece_address[63:0], count_minus_one[85:64], interrupt_on_done[86],
    // slot_index[90:87], round_end[91], transfer_done[92], zero pad
    output logic [sgpd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // align_error
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import sgpd_pkg::*;

    cmd_t    cmd;
    status_t status;
    desc_t   desc;

    sgpd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sgpd_dpath
    #(
        .PRDT_SLOTS      (PRDT_SLOTS),
        .MAX_PIECE_BYTES (MAX_PIECE_BYTES)
    )
    u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_kind           (s_axis_tuser),
        .in_transfer_bytes (s_axis_tdata[31:0]),
        .in_sg_address     (s_axis_tdata[95:32]),
        .in_sg_length      (s_axis_tdata[122:96]),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_desc          (desc),
        .cmd               (cmd),
        .status            (status)
    );

    assign m_axis_tdata = {3'b000, desc.transfer_done, desc.round_end, desc.slot_index,
                           desc.interrupt_on_done, desc.count_minus_one,
                           desc.piece_address};
    assign m_axis_tuser = desc.align_error;
    assign m_axis_tlast = desc.last;

    // an error result always ends the transaction's results
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error result without tlast");

    // finishing the transfer closes the round and ends the results
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[92] |-> m_axis_tdata[91] && m_axis_tlast)
        else $error("transfer_done without round_end or tlast");

    // no new input while an accepted entry is being cut
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input taken while an entry is being cut");

endmodule

>>> test/tb_sg_to_prdt_descriptor_builder_core.sv
`timescale 1ns / 1ps

module tb_sg_to_prdt_descriptor_builder_core;

    import sgpd_pkg::*;

    localparam int PRDT_SLOTS      = 16;
    localparam int MAX_PIECE_BYTES = 4194304;
    localparam int DRAIN_CYCLES    = 64;
    localparam int LIMIT_CYCLES    = 3000000;
    localparam logic OP_START      = 1'b0;
    localparam logic OP_ENTRY      = 1'b1;

    typedef struct {
        logic              opcode;
        logic [BYTES_W-1:0] transfer_bytes;
        logic [ADDR_W-1:0]  sg_address;
        logic [LEN_W-1:0]   sg_length;
    } sg_item_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SECTOR_W-1:0]    cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // transfer_bytes, sg_address, sg_length, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // opcode
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // piece_address, count_minus_one, interrupt_on_done, slot_index, round_end,
    // transfer_done, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // align_error
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // pending input transactions and descriptors still to come
    sg_item_t sg_item_q[$];
    desc_t    expected_desc_q[$];
    sg_item_t item_on_bus;
    bit       item_held;

    // predictor copy of the block's registers and transfer state
    logic [SECTOR_W-1:0] cfg_sector;
    logic                cfg_align;
    logic [BYTES_W-1:0]  bytes_left;
    logic [BYTES_W-1:0]  round_total;
    int                  round_slot;
    bit                  stopped;

    int gap_pct;
    int fail_cnt;
    int items_accepted;
    int desc_checked;
    int round_closes;
    int stop_results;
    int cycle_cnt;

    sg_to_prdt_descriptor_builder_core
    #(
        .PRDT_SLOTS      (PRDT_SLOTS),
        .MAX_PIECE_BYTES (MAX_PIECE_BYTES)
    )
    DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cut one entry into descriptors, or load a new transfer.
    task automatic build_descriptors(input sg_item_t it);
        longint unsigned len;
        longint unsigned offset;
        longint unsigned piece;
        longint unsigned ss;
        longint unsigned rem;
        bit              close;
        desc_t           d;
        desc_t           rows[$];
        if (it.opcode == OP_START)
        begin
            bytes_left  = it.transfer_bytes;
            round_total = '0;
            round_slot  = 0;
            stopped     = 1'b0;
            return;
        end
        len    = it.sg_length;
        offset = 0;
        while (!stopped && bytes_left != 0 && offset < len && rows.size() < RESULT_LIMIT)
        begin
            piece = MAX_PIECE_BYTES;
            if (bytes_left < piece)
                piece = bytes_left;
            if (len - offset < piece)
                piece = len - offset;
            // last slot of a round, transfer not finishing here: trim to whole sectors
            if (round_slot == PRDT_SLOTS - 1 && cfg_align && piece != bytes_left)
            begin
                ss  = (cfg_sector == 0) ? 1 : cfg_sector;
                rem = (round_total + piece) % ss;
                if (rem != 0)
                begin
                    if (piece < ss)
                    begin
                        d             = '0;
                        d.slot_index  = round_slot[SLOT_IDX_W-1:0];
                        d.align_error = 1'b1;
                        rows.push_back(d);
                        stopped = 1'b1;
                        break;
                    end
                    piece -= rem;
                end
            end
            bytes_left  -= piece[BYTES_W-1:0];
            round_total += piece[BYTES_W-1:0];
            close = (round_slot >= PRDT_SLOTS - 1) || (bytes_left == 0);
            d                   = '0;
            d.piece_address     = it.sg_address + offset;
            d.count_minus_one   = CM1_W'(piece - 1);
            d.interrupt_on_done = close;
            d.slot_index        = round_slot[SLOT_IDX_W-1:0];
            d.round_end         = close;
            d.transfer_done     = (bytes_left == 0);
            rows.push_back(d);
            offset += piece;
            if (close)
            begin
                round_slot  = 0;
                round_total = '0;
            end
            else
                round_slot++;
        end
        if (rows.size() > 0)
        begin
            d      = rows.pop_back();
            d.last = 1'b1;
            rows.push_back(d);
        end
        foreach (rows[i])
            expected_desc_q.push_back(rows[i]);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                build_descriptors(item_on_bus);
                items_accepted++;
                item_held = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sg_item_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    item_on_bus = sg_item_q.pop_front();
                    item_held   = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'd0, item_on_bus.sg_length, item_on_bus.sg_address,
                                      item_on_bus.transfer_bytes};
                    s_axis_tuser  <= item_on_bus.opcode;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        desc_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= gap_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_desc_q.size() == 0)
                begin
                    $error("descriptor with no expectation: tdata 0x%0h tuser %0b tlast %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_desc_q.pop_front();
                    check_field("piece_address", want.piece_address, m_axis_tdata[63:0]);
                    check_field("count_minus_one", want.count_minus_one, m_axis_tdata[85:64]);
                    check_field("interrupt_on_done", want.interrupt_on_done, m_axis_tdata[86]);
                    check_field("slot_index", want.slot_index, m_axis_tdata[90:87]);
                    check_field("round_end", want.round_end, m_axis_tdata[91]);
                    check_field("transfer_done", want.transfer_done, m_axis_tdata[92]);
                    check_field("align_error", want.align_error, m_axis_tuser);
                    check_field("last", want.last, m_axis_tlast);
                    desc_checked++;
                    if (want.round_end)
                        round_closes++;
                    if (want.align_error)
                        stop_results++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d descriptors outstanding",
                     cycle_cnt, expected_desc_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    task automatic push_item(logic op, logic [BYTES_W-1:0] tb, logic [ADDR_W-1:0] addr,
                             logic [LEN_W-1:0] len);
        sg_item_t it;
        it.opcode         = op;
        it.transfer_bytes = tb;
        it.sg_address     = addr;
        it.sg_length      = len;
        sg_item_q.push_back(it);
    endtask

    task automatic push_start(logic [BYTES_W-1:0] tb);
        push_item(OP_START, tb, rand_addr(), LEN_W'($urandom));
    endtask

    task automatic push_entry(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
        push_item(OP_ENTRY, $urandom, addr, len);
    endtask

    // one start followed by the entries of a transfer, at times with one extra entry
    task automatic push_random_transfer(output int count);
        int               n;
        int               kind;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] lens[$];
        longint unsigned  total;
        longint unsigned  ss;
        longint unsigned  tb;
        ss    = (cfg_sector == 0) ? 1 : cfg_sector;
        kind  = $urandom_range(9);
        n     = (kind == 9) ? $urandom_range(1, 4) : $urandom_range(3, 24);
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            if (kind == 9)
                len = LEN_W'($urandom_range(1, 1 << 26));
            else if ($urandom_range(1))
                len = LEN_W'(ss * $urandom_range(1, 4));
            else
                len = LEN_W'($urandom_range(1, 2 * ss + 64));
            lens.push_back(len);
            total += len;
        end
        case ($urandom_range(3))
            0: tb = total - $urandom_range(0, lens[n-1] - 1);
            1: tb = total + $urandom_range(1, 5000);
            default: tb = total;
        endcase
        push_start(BYTES_W'(tb));
        foreach (lens[i])
            push_entry(rand_addr(), lens[i]);
        count = n + 1;
        if ($urandom_range(3) == 0)
        begin
            push_entry(rand_addr(), LEN_W'($urandom_range(1, 4096)));
            count++;
        end
    endtask

    task automatic wait_idle();
        while (sg_item_q.size() != 0 || item_held || expected_desc_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SECTOR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_SECTOR_SIZE)
            cfg_sector = val;
        else
            cfg_align = val[0];
    endtask

    task automatic run_phase(logic [SECTOR_W-1:0] sector, logic align, int gap, int quota);
        int pushed;
        int k;
        wait_idle();
        write_reg(REG_SECTOR_SIZE, sector);
        write_reg(REG_ALIGN_ROUNDS, {{(SECTOR_W-1){1'b0}}, align});
        gap_pct = gap;
        pushed  = 0;
        while (pushed < quota)
        begin
            if ($urandom_range(9) < 8)
            begin
                push_random_transfer(k);
                pushed += k;
            end
            else
            begin
                push_item(1'($urandom_range(1)), $urandom, rand_addr(),
                          ($urandom_range(3) == 0) ? LEN_W'($urandom) :
                                                     LEN_W'($urandom_range(0, 4096)));
                pushed++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        item_held      = 1'b0;
        cfg_sector     = SECTOR_SIZE_RESET;
        cfg_align      = 1'b1;
        bytes_left     = '0;
        round_total    = '0;
        round_slot     = 0;
        stopped        = 1'b0;
        gap_pct        = 20;
        fail_cnt       = 0;
        items_accepted = 0;
        desc_checked   = 0;
        round_closes   = 0;
        stop_results   = 0;
        cycle_cnt      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings
        push_entry(rand_addr(), 27'd1000);          // nothing loaded yet
        push_start(32'd0);
        push_entry(rand_addr(), 27'd1000);          // empty transfer
        push_start(32'd1000);
        push_entry(rand_addr(), 27'd0);             // zero length
        push_entry(64'hFFFF_FFFF_FFFF_FFFF, 27'd600);
        push_entry(64'd0, 27'd67108864);            // finishes the transfer
        push_entry(rand_addr(), 27'd5);             // transfer already done
        push_start(32'hFFFF_FFFF);
        // address wrap, trimmed last slot and the per-transaction result cap
        push_entry(64'hFFFF_FFFF_FFE0_0000, 27'h7FF_FFFF);
        push_start(32'd100000000);
        push_entry(rand_addr(), 27'd62914660);      // last slot too short: stop
        push_entry(rand_addr(), 27'd1000);          // ignored after the stop
        push_start(32'd200000000);
        push_entry(rand_addr(), 27'd62915260);      // trimmed, rest in next round
        push_start(32'd62914660);
        push_entry(rand_addr(), 27'd67108864);      // ends exactly in the last slot
        push_start(32'd3000);
        push_entry(rand_addr(), 27'd1000);
        push_entry(rand_addr(), 27'd1000);
        push_entry(rand_addr(), 27'd1000);

        run_phase(13'd1, 1'b1, 20, 52);
        run_phase(13'd4096, 1'b1, 0, 52);           // no backpressure, no gaps
        run_phase(13'd512, 1'b0, 20, 52);
        run_phase(13'd0, 1'b1, 20, 52);
        run_phase(13'd520, 1'b1, 20, 52);
        run_phase(13'd4095, 1'b1, 20, 52);
        wait_idle();

        $display("%0d input transactions, %0d descriptors checked", items_accepted,
                 desc_checked);
        $display("%0d rounds closed, %0d alignment stops, sector sizes 0..4096, align on/off",
                 round_closes, stop_results);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/sgpd_pkg.sv
sv/sgpd_rem.sv
sv/sgpd_ctrl.sv
sv/sgpd_dpath.sv
sv/sg_to_prdt_descriptor_builder_core.sv
test/tb_sg_to_prdt_descriptor_builder_core.sv
